// File: sv/okvt_pkg.sv
// Shared types, opcodes and defaults for the ordered key/value table.
`timescale 1ns / 1ps

package okvt_pkg;

    // Default sizes
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Request opcodes
    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_UPDATE    = 3'd1;
    localparam logic [2:0] OP_UPSERT    = 3'd2;
    localparam logic [2:0] OP_ERASE     = 3'd3;
    localparam logic [2:0] OP_LOOKUP    = 3'd4;
    localparam logic [2:0] OP_READ_POS  = 3'd5;

    // Request item as it arrives on the port
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] req_key;
        logic [31:0] req_value;
        logic [3:0]  position;
    } okvt_req_t;

    // Result item as it leaves the port
    typedef struct packed {
        logic        success;
        logic        table_full;
        logic [31:0] out_key;
        logic [31:0] out_value;
        logic [4:0]  entry_count;
    } okvt_rsp_t;

    // Decoded action flags of one item
    typedef struct packed {
        logic ins_miss;   // insert when the key is absent
        logic upd_hit;    // overwrite the value when the key is present
        logic erase;
        logic lookup;
        logic rd_pos;
    } okvt_kind_t;

    // Classified item held in the queue between front and back
    typedef struct packed {
        okvt_kind_t  kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [3:0]  position;
    } okvt_cmd_t;

endpackage

// File: sv/okvt_front.sv
// Front end: accepts request items, decodes them and queues them for the back end.
`timescale 1ns / 1ps

module okvt_front #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  okvt_pkg::okvt_req_t  request,
    input  logic                 pop,
    output okvt_pkg::okvt_cmd_t  head,
    output logic                 empty
);
    import okvt_pkg::*;

    localparam logic [63:0] KEY_MASK64 =
        (KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [63:0] VAL_MASK64 =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

    okvt_cmd_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    okvt_cmd_t  cmd;

    // Decode the opcode into action flags and trim key and value
    always_comb
    begin
        cmd.kind     = '0;
        cmd.key      = request.req_key & KEY_MASK64[31:0];
        cmd.value    = request.req_value & VAL_MASK64[31:0];
        cmd.position = request.position;
        case (request.opcode)
            OP_INSERT:   cmd.kind.ins_miss = 1'b1;
            OP_UPDATE:   cmd.kind.upd_hit  = 1'b1;
            OP_UPSERT:
            begin
                cmd.kind.ins_miss = 1'b1;
                cmd.kind.upd_hit  = 1'b1;
            end
            OP_ERASE:    cmd.kind.erase    = 1'b1;
            OP_LOOKUP:   cmd.kind.lookup   = 1'b1;
            OP_READ_POS: cmd.kind.rd_pos   = 1'b1;
            default:     cmd.kind          = '0;
        endcase
    end

    // Queue bookkeeping
    assign busy  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign push  = start && !busy;
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the decoded item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// File: sv/okvt_back.sv
// Back end: entry cells with parallel key match, shift on insert and erase, result register.
`timescale 1ns / 1ps

module okvt_back #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  okvt_pkg::okvt_cmd_t  head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 done,
    output okvt_pkg::okvt_rsp_t  result
);
    import okvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } okvt_state_t;

    okvt_state_t             state_reg;
    okvt_state_t             state_next;
    okvt_cmd_t               cmd_reg;
    logic [KEY_BITS-1:0]     key_reg [CAPACITY];
    logic [KEY_BITS-1:0]     key_next [CAPACITY];
    logic [VALUE_BITS-1:0]   val_reg [CAPACITY];
    logic [VALUE_BITS-1:0]   val_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CAPACITY-1:0]     hit_vec_reg;
    logic [CAPACITY-1:0]     hit_vec_next;
    logic [CAPACITY-1:0]     from_hit;
    logic                    done_reg;
    okvt_rsp_t               result_reg;
    okvt_rsp_t               result_next;
    logic [63:0]             key_wide;
    logic [KEY_BITS-1:0]     cell_key;
    logic [63:0]             val_wide;
    logic [VALUE_BITS-1:0]   cell_val;
    logic                    hit_any;
    logic [VALUE_BITS-1:0]   hit_val;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_val;
    logic                    is_full;
    logic                    pos_ok;
    logic                    ok;
    logic                    full;
    logic [63:0]             okey_wide;
    logic [63:0]             oval_wide;
    logic [31:0]             count_wide;

    assign key_wide = {32'b0, cmd_reg.key};
    assign cell_key = key_wide[KEY_BITS-1:0];
    assign val_wide = {32'b0, cmd_reg.value};
    assign cell_val = val_wide[VALUE_BITS-1:0];

    // Sequence: take an item, match keys, execute
    assign pop = ((state_reg == S_IDLE) || (state_reg == S_EXEC)) && !empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = empty ? S_IDLE : S_MATCH;
            S_MATCH: state_next = S_EXEC;
            S_EXEC:  state_next = empty ? S_IDLE : S_MATCH;
            default: state_next = S_IDLE;
        endcase
    end

    // Compare the key against every valid cell
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_vec_next[i] = (i < 32'(count_reg)) && (key_reg[i] == cell_key);
        end
    end

    // Gather read data for the hit cell and the requested position
    always_comb
    begin
        logic acc;
        acc     = 1'b0;
        hit_val = '0;
        rd_key  = '0;
        rd_val  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            acc         = acc | hit_vec_reg[i];
            from_hit[i] = acc;
            if (hit_vec_reg[i])
            begin
                hit_val = hit_val | val_reg[i];
            end
            if (32'(cmd_reg.position) == i)
            begin
                rd_key = key_reg[i];
                rd_val = val_reg[i];
            end
        end
    end

    assign hit_any = |hit_vec_reg;
    assign is_full = (32'(count_reg) == CAPACITY);
    assign pos_ok  = (32'(cmd_reg.position) < 32'(count_reg));

    // Execute the item on the cells
    always_comb
    begin
        key_next   = key_reg;
        val_next   = val_reg;
        count_next = count_reg;
        ok         = 1'b0;
        full       = 1'b0;
        okey_wide  = key_wide;
        oval_wide  = '0;
        if (state_reg == S_EXEC)
        begin
            // Insert at the front, shifting older entries back
            if (cmd_reg.kind.ins_miss && !hit_any)
            begin
                if (is_full)
                begin
                    full = 1'b1;
                end
                else
                begin
                    for (int i = CAPACITY - 1; i > 0; i--)
                    begin
                        key_next[i] = key_reg[i-1];
                        val_next[i] = val_reg[i-1];
                    end
                    key_next[0] = cell_key;
                    val_next[0] = cell_val;
                    count_next  = count_reg + CNT_W'(1);
                    ok          = 1'b1;
                end
            end
            // Overwrite the value of the hit cell
            if (cmd_reg.kind.upd_hit && hit_any)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (hit_vec_reg[i])
                    begin
                        val_next[i] = cell_val;
                    end
                end
                ok = 1'b1;
            end
            // Drop the hit cell and close the gap
            if (cmd_reg.kind.erase && hit_any)
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (from_hit[i])
                    begin
                        key_next[i] = key_reg[i+1];
                        val_next[i] = val_reg[i+1];
                    end
                end
                count_next = count_reg - CNT_W'(1);
                ok         = 1'b1;
            end
            if (cmd_reg.kind.lookup && hit_any)
            begin
                oval_wide = 64'(hit_val);
                ok        = 1'b1;
            end
            if (cmd_reg.kind.rd_pos && pos_ok)
            begin
                okey_wide = 64'(rd_key);
                oval_wide = 64'(rd_val);
                ok        = 1'b1;
            end
        end
    end

    assign count_wide = 32'(count_next);

    always_comb
    begin
        result_next.success     = ok;
        result_next.table_full  = full;
        result_next.out_key     = okey_wide[31:0];
        result_next.out_value   = oval_wide[31:0];
        result_next.entry_count = count_wide[4:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    // Payload registers and cells
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (state_reg == S_MATCH)
        begin
            hit_vec_reg <= hit_vec_next;
        end
        if (state_reg == S_EXEC)
        begin
            result_reg <= result_next;
        end
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Keys are unique, so at most one cell matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(hit_vec_reg))
        else $error("more than one cell matched the key");

    // Entry count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("entry count beyond capacity");

    // A result follows the execute state
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_EXEC))
        else $error("result strobe without execute");

    // A failed insert never reports success
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.success && result_reg.table_full))
        else $error("success and full flag together");

endmodule

// File: sv/ordered_key_value_table_core.sv
// Top level of the ordered key/value table: front end, item queue and back end.
`timescale 1ns / 1ps

// Bounded table of unique keys, newest entry at position 0.
// Request channel: drive request and raise start; the item is taken at the
// rising edge where start is high and busy is low. busy rises only while
// the two-entry item queue is full.
// Result channel: done is high for exactly one cycle with the result; the
// receiver cannot stall, so it must take the result in that cycle.
// An item passes through the item queue, the key match and the execute step
// before done rises with its result.
// The back end matches keys in its match state and updates the cells in the
// execute state that follows; the next match must see the updated cells, so
// a new item is matched only after the last one has executed.
// Results come out in request order, one per item.
// Reset clears the entry count, the queue and the sequencer; the key and
// value cells are not cleared, since only positions below the count are read.
module ordered_key_value_table_core #(
    parameter int CAPACITY   = okvt_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = okvt_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = okvt_pkg::DEF_VALUE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  okvt_pkg::okvt_req_t  request,
    output logic                 done,
    output okvt_pkg::okvt_rsp_t  result
);
    import okvt_pkg::*;

    okvt_cmd_t head;
    logic      empty;
    logic      pop;

    // Accept and classify
    okvt_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .pop     (pop),
        .head    (head),
        .empty   (empty)
    );

    // Execute on the table
    okvt_back #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// File: test/ordered_key_value_table_core_tb.sv
// Self-checking testbench for the ordered key/value table, with directed rows and random traffic.
`timescale 1ns / 1ps

module ordered_key_value_table_core_tb;

    import okvt_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_BLOCKS = 14;
    localparam int BLOCK_ITEMS   = 100;
    localparam int KEY_POOL_SIZE = 20;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 16;
    localparam int PRINT_LIMIT   = 100;

    // Opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // Opcode mix of one random block
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } traffic_mix_t;

    // One directed row: count items with key and value stepping by one
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] key;
        logic [31:0] value;
        logic [3:0]  position;
        logic [4:0]  count;
        logic        typed;
        okvt_rsp_t   want;
    } plan_row_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    okvt_req_t request = '0;
    logic      done;
    okvt_rsp_t result;

    // Shadow copy of the table contents
    logic [31:0] stored_keys [CAPACITY];
    logic [31:0] stored_values [CAPACITY];
    int          entry_total = 0;

    okvt_rsp_t   pending_results [$];
    logic [31:0] key_pool [KEY_POOL_SIZE];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;

    plan_row_t plan [DIRECTED_ROWS] = '{
        // empty table: misses of every kind
        '{OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 5'd0}},
        '{OP_READ_POS, 32'hDEAD_BEEF, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'hDEAD_BEEF, 32'h0000_0000, 5'd0}},
        '{OP_UPDATE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1,
          '{1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0}},
        '{OP_ERASE,    32'h0000_0007, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0007, 32'h0000_0000, 5'd0}},
        // inserts, duplicate insert, both upsert paths, then update, lookup, read and erase hits
        '{OP_INSERT,   32'h0000_0000, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 5'd1}},
        '{OP_INSERT,   32'h0000_0000, 32'h0000_0001, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 5'd1}},
        '{OP_UPSERT,   32'hFFFF_FFFF, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 5'd2}},
        '{OP_UPSERT,   32'h0000_0000, 32'h1234_5678, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 5'd2}},
        '{OP_UPDATE,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 5'd2}},
        '{OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 32'h1234_5678, 5'd2}},
        '{OP_READ_POS, 32'h0000_0055, 32'h0000_0000, 4'd1,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 32'h1234_5678, 5'd2}},
        '{OP_ERASE,    32'h0000_0000, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 5'd1}},
        // unused opcodes do nothing
        '{OP_SPARE_A,  32'h0000_0003, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0003, 32'h0000_0000, 5'd1}},
        '{OP_SPARE_B,  32'h0000_0004, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0004, 32'h0000_0000, 5'd1}},
        // fill the table, then hit it while full
        '{OP_INSERT,   32'h8000_0000, 32'h5A5A_5A5A, 4'd0,  5'd15, 1'b0, '0},
        '{OP_INSERT,   32'h0000_1234, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b1, 32'h0000_1234, 32'h0000_0000, 5'd16}},
        '{OP_UPSERT,   32'h0000_5678, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b1, 32'h0000_5678, 32'h0000_0000, 5'd16}},
        '{OP_UPSERT,   32'hFFFF_FFFF, 32'h0F0F_0F0F, 4'd0,  5'd1,  1'b1,
          '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 5'd16}},
        '{OP_READ_POS, 32'h0000_0000, 32'h0000_0000, 4'd15, 5'd1,  1'b1,
          '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 5'd16}},
        '{OP_READ_POS, 32'h0000_0000, 32'h0000_0000, 4'd0,  5'd1,  1'b0, '0},
        // erase from the middle, then miss past the end
        '{OP_ERASE,    32'h8000_0007, 32'h0000_0000, 4'd0,  5'd1,  1'b0, '0},
        '{OP_LOOKUP,   32'h0000_0012, 32'h0000_0000, 4'd0,  5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0012, 32'h0000_0000, 5'd15}},
        '{OP_READ_POS, 32'h0000_0009, 32'h0000_0000, 4'd15, 5'd1,  1'b1,
          '{1'b0, 1'b0, 32'h0000_0009, 32'h0000_0000, 5'd15}}
    };

    ordered_key_value_table_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Apply one item to the shadow table and return the result it gives
    function automatic okvt_rsp_t apply_request(input okvt_req_t item);
        okvt_rsp_t rsp;
        int        hit;
        hit = -1;
        for (int i = 0; i < entry_total; i++)
        begin
            if (stored_keys[i] == item.req_key)
            begin
                hit = i;
            end
        end
        rsp = '0;
        rsp.out_key = item.req_key;
        case (item.opcode)
            OP_INSERT, OP_UPSERT:
            begin
                if (hit >= 0)
                begin
                    if (item.opcode == OP_UPSERT)
                    begin
                        stored_values[hit] = item.req_value;
                        rsp.success = 1'b1;
                    end
                end
                else if (entry_total >= CAPACITY)
                begin
                    rsp.table_full = 1'b1;
                end
                else
                begin
                    // shift toward the old end, newest goes to the front
                    for (int i = entry_total; i > 0; i--)
                    begin
                        stored_keys[i]   = stored_keys[i - 1];
                        stored_values[i] = stored_values[i - 1];
                    end
                    stored_keys[0]   = item.req_key;
                    stored_values[0] = item.req_value;
                    entry_total++;
                    rsp.success = 1'b1;
                end
            end
            OP_UPDATE:
            begin
                if (hit >= 0)
                begin
                    stored_values[hit] = item.req_value;
                    rsp.success = 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (hit >= 0)
                begin
                    // close the gap toward the front
                    for (int i = hit; i + 1 < entry_total; i++)
                    begin
                        stored_keys[i]   = stored_keys[i + 1];
                        stored_values[i] = stored_values[i + 1];
                    end
                    entry_total--;
                    rsp.success = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    rsp.out_value = stored_values[hit];
                    rsp.success   = 1'b1;
                end
            end
            OP_READ_POS:
            begin
                if (int'(item.position) < entry_total)
                begin
                    rsp.out_key   = stored_keys[item.position];
                    rsp.out_value = stored_values[item.position];
                    rsp.success   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        rsp.entry_count = 5'(entry_total);
        return rsp;
    endfunction

    // Present one item, after a random gap unless no_gaps is set; wait until taken, log its result
    task automatic send_item(input okvt_req_t item, input logic typed, input okvt_rsp_t want);
        int        gap;
        okvt_rsp_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_request(item);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Hold off until every logged result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Pick a key: mostly stored or pooled keys so that hits are common
    function automatic logic [31:0] draw_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && entry_total > 0)
        begin
            return stored_keys[$urandom_range(0, entry_total - 1)];
        end
        if (roll < 85)
        begin
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end
        if (roll < 90)
        begin
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return $urandom;
    endfunction

    // Pick an opcode weighted by the traffic mix, with a few unused ones as noise
    function automatic logic [2:0] draw_opcode(input traffic_mix_t mix);
        logic [2:0]  ops [6];
        int unsigned weight [6];
        int unsigned roll;
        int unsigned acc;
        logic [2:0]  chosen;
        ops = '{OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP, OP_READ_POS};
        case (mix)
            MIX_FILL:     weight = '{35, 10, 20,  5, 15, 15};
            MIX_BALANCED: weight = '{15, 15, 15, 15, 20, 20};
            default:      weight = '{ 5, 10,  5, 45, 15, 20};
        endcase
        if ($urandom_range(0, 99) < 2)
        begin
            return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
        end
        roll   = $urandom_range(0, 99);
        acc    = 0;
        chosen = OP_READ_POS;
        for (int k = 5; k >= 0; k--)
        begin
            acc = 0;
            for (int j = 0; j <= k; j++)
            begin
                acc += weight[j];
            end
            if (roll < acc)
            begin
                chosen = ops[k];
            end
        end
        return chosen;
    endfunction

    // Check each result against the oldest logged one and watch for a stall
    always @(posedge clk)
    begin
        okvt_rsp_t want;
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, key %h", result.out_key));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.success !== want.success)
                begin
                    report_mismatch($sformatf("success %b, want %b", result.success,
                                              want.success));
                end
                if (result.table_full !== want.table_full)
                begin
                    report_mismatch($sformatf("table_full %b, want %b", result.table_full,
                                              want.table_full));
                end
                if (result.out_key !== want.out_key)
                begin
                    report_mismatch($sformatf("out_key %h, want %h", result.out_key,
                                              want.out_key));
                end
                if (result.out_value !== want.out_value)
                begin
                    report_mismatch($sformatf("out_value %h, want %h", result.out_value,
                                              want.out_value));
                end
                if (result.entry_count !== want.entry_count)
                begin
                    report_mismatch($sformatf("entry_count %0d, want %0d", result.entry_count,
                                              want.entry_count));
                end
            end
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Reset, directed rows, random blocks, drain, verdict
    initial
    begin
        okvt_req_t    item;
        traffic_mix_t mix;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed rows
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            for (int r = 0; r < int'(plan[row].count); r++)
            begin
                item.opcode    = plan[row].opcode;
                item.req_key   = plan[row].key + 32'(r);
                item.req_value = plan[row].value + 32'(r);
                item.position  = plan[row].position;
                send_item(item, plan[row].typed, plan[row].want);
            end
        end
        wait_drained();

        // random blocks cycling through fill, balanced and drain mixes
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            mix     = traffic_mix_t'(blk % 3);
            no_gaps = (blk % 4 == 1);
            for (int k = 0; k < KEY_POOL_SIZE; k++)
            begin
                key_pool[k] = $urandom;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                item.opcode    = draw_opcode(mix);
                item.req_key   = draw_key();
                item.req_value = $urandom;
                item.position  = 4'($urandom_range(0, 15));
                send_item(item, 1'b0, '0);
            end
            // let the block run dry at every block boundary
            wait_drained();
        end

        // catch any stray result after the last one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
